// File: hw/rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg - shared definitions for the point to segment distance block
// result format, path codes and parameter defaults
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  // result format: unsigned q32.16
  localparam int unsigned OUT_FRAC = 16;
  localparam int unsigned OUT_W    = 48;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // 1000000.0 in q32.16
  localparam logic [OUT_W-1:0] SENTINEL_Q16 = OUT_W'(64'd1000000 << OUT_FRAC);

  // 40 * |x| < 1.0 is the exact test for |x| < 0.025
  localparam int unsigned TOL_MUL = 40;

  typedef enum logic [1:0] {
    PATH_SHORT   = 2'd0,
    PATH_FLAT    = 2'd1,
    PATH_INSIDE  = 2'd2,
    PATH_OUTSIDE = 2'd3
  } path_e;

endpackage

// File: hw/rtl/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div - pipelined restoring divider
// one quotient bit per stage, a new word can enter every cycle; the
// quotient must fit in W bits (high half of the numerator below den)
// ----------------------------------------------------------------------------
module psd_div #(
  parameter int unsigned W     = 50,
  parameter int unsigned TAG_W = 52
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [2*W-1:0]   num_i,
  input  logic [W-1:0]     den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [W-1:0]     quo_o,
  output logic [TAG_W-1:0] tag_o
);

  logic             vld_q [W];
  logic [W-1:0]     rem_q [W];
  logic [W-1:0]     nlo_q [W];
  logic [W-1:0]     quo_q [W];
  logic [W-1:0]     den_q [W];
  logic [TAG_W-1:0] tag_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic             vld_p;
    logic [W-1:0]     rem_p;
    logic [W-1:0]     nlo_p;
    logic [W-1:0]     quo_p;
    logic [W-1:0]     den_p;
    logic [TAG_W-1:0] tag_p;
    logic [W:0]       rem_x;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_p = valid_i;
      assign rem_p = num_i[2*W-1:W];
      assign nlo_p = num_i[W-1:0];
      assign quo_p = '0;
      assign den_p = den_i;
      assign tag_p = tag_i;
    end else begin : g_next
      assign vld_p = vld_q[k-1];
      assign rem_p = rem_q[k-1];
      assign nlo_p = nlo_q[k-1];
      assign quo_p = quo_q[k-1];
      assign den_p = den_q[k-1];
      assign tag_p = tag_q[k-1];
    end

    // shift in the next numerator bit and try the subtract
    assign rem_x = {rem_p, nlo_p[W-1]};
    assign ge    = (rem_x >= {1'b0, den_p});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? W'(rem_x - {1'b0, den_p}) : rem_x[W-1:0];
      nlo_q[k] <= {nlo_p[W-2:0], 1'b0};
      quo_q[k] <= {quo_p[W-2:0], ge};
      den_q[k] <= den_p;
      tag_q[k] <= tag_p;
    end
  end

  assign valid_o = vld_q[W-1];
  assign quo_o   = quo_q[W-1];
  assign tag_o   = tag_q[W-1];

endmodule

// File: hw/rtl/point_segment_distance_sq.sv
// ----------------------------------------------------------------------------
// point_segment_distance_sq - squared distance from a point to a segment
// fixed-point geometry pipeline with exact projection test and divide
// ----------------------------------------------------------------------------
// usage
//   a word is a point p plus segment start s and end e, three signed
//   coordinates each; it is taken on a clock edge with start_i high and
//   busy_o low. busy_o is always low, so a word can enter every cycle.
//   each result (dist_sq_o, path_taken_o) is shown for exactly one cycle
//   with valid_o high; the receiver cannot stall, so there is no back
//   pressure anywhere in the pipe.
// pipeline and throughput
//   five front stages (differences, products, sums, classify and
//   partial products of dot^2, numerator add), one stage per quotient
//   bit in the restoring divider (2*COORD_WIDTH + 2 bits), and one
//   output stage. throughput is one word per cycle; the divider depth
//   sets the latency.
// reset
//   rst_ni clears only the valid bits; words in flight are dropped and
//   no result comes out until new words have gone through the pipe.
// ----------------------------------------------------------------------------
module point_segment_distance_sq #(
  parameter int unsigned COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = psd_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_z_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_z_i,
  output logic                          valid_o,
  output logic [psd_pkg::OUT_W-1:0]     dist_sq_o,
  output logic [1:0]                    path_taken_o
);

  // difference width, product width, sum width (|sum| < 3 * 2^(2*cw))
  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned SQW = 2 * COORD_WIDTH;
  localparam int unsigned LW  = 2 * COORD_WIDTH + 2;
  localparam int unsigned DTW = LW + 1;
  localparam int unsigned HW  = LW / 2;
  localparam int unsigned EW  = LW + 8;
  localparam int unsigned TAG_W = LW + 2;
  // format change to q.16
  localparam int unsigned XW  = LW + psd_pkg::OUT_FRAC;
  localparam int unsigned SHR = (2 * FRAC_BITS > psd_pkg::OUT_FRAC) ?
                                (2 * FRAC_BITS - psd_pkg::OUT_FRAC) : 0;
  localparam int unsigned SHL = (2 * FRAC_BITS < psd_pkg::OUT_FRAC) ?
                                (psd_pkg::OUT_FRAC - 2 * FRAC_BITS) : 0;
  localparam int unsigned LAT = LW + 6;

  localparam logic [LW-1:0]          ONE_Q = LW'(1) << (2 * FRAC_BITS);
  localparam logic [COORD_WIDTH+5:0] TOL_ONE = (COORD_WIDTH + 6)'(1) << FRAC_BITS;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---------------- stage 1: a = p - s, d = e - s ----------------
  logic signed [COORD_WIDTH-1:0] p_c [3];
  logic signed [COORD_WIDTH-1:0] s_c [3];
  logic signed [COORD_WIDTH-1:0] e_c [3];

  assign p_c[0] = point_x_i;
  assign p_c[1] = point_y_i;
  assign p_c[2] = point_z_i;
  assign s_c[0] = start_x_i;
  assign s_c[1] = start_y_i;
  assign s_c[2] = start_z_i;
  assign e_c[0] = end_x_i;
  assign e_c[1] = end_y_i;
  assign e_c[2] = end_z_i;

  logic              v1_q;
  logic signed [DW-1:0] a1_q [3];
  logic signed [DW-1:0] d1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a1_q[i] <= DW'(p_c[i]) - DW'(s_c[i]);
      d1_q[i] <= DW'(e_c[i]) - DW'(s_c[i]);
    end
  end

  // ---------------- stage 2: per-axis products ----------------
  logic                     v2_q;
  logic [SQW-1:0]           aa2_q [3];
  logic [SQW-1:0]           dd2_q [3];
  logic signed [PW-1:0]     ad2_q [3];
  logic [COORD_WIDTH-1:0]   dz2_q;
  logic signed [PW-1:0]     aa_c [3];
  logic signed [PW-1:0]     dd_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      aa_c[i] = a1_q[i] * a1_q[i];
      dd_c[i] = d1_q[i] * d1_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      aa2_q[i] <= aa_c[i][SQW-1:0];
      dd2_q[i] <= dd_c[i][SQW-1:0];
      ad2_q[i] <= a1_q[i] * d1_q[i];
    end
    // |dz| < 2^cw always fits
    dz2_q <= d1_q[2][DW-1] ? COORD_WIDTH'(-d1_q[2]) : d1_q[2][COORD_WIDTH-1:0];
  end

  // ---------------- stage 3: L, A2, dot, flat test ----------------
  logic                  v3_q;
  logic [LW-1:0]         len2_3_q;
  logic [LW-1:0]         a2_3_q;
  logic signed [DTW-1:0] dot3_q;
  logic                  flat3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    len2_3_q <= LW'(dd2_q[0]) + LW'(dd2_q[1]) + LW'(dd2_q[2]);
    a2_3_q   <= LW'(aa2_q[0]) + LW'(aa2_q[1]) + LW'(aa2_q[2]);
    dot3_q   <= DTW'(ad2_q[0]) + DTW'(ad2_q[1]) + DTW'(ad2_q[2]);
    flat3_q  <= ((COORD_WIDTH + 6)'(dz2_q) * (COORD_WIDTH + 6)'(psd_pkg::TOL_MUL))
                < TOL_ONE;
  end

  // ---------------- stage 4: classify, partial products of dot^2 ----------------
  logic signed [EW-1:0] dot_e;
  logic signed [EW-1:0] len_e;
  logic                 above_c;
  logic                 below_c;
  logic [LW-1:0]        md_c;
  psd_pkg::path_e       path_c;

  assign dot_e   = EW'(dot3_q);
  assign len_e   = $signed({{(EW-LW){1'b0}}, len2_3_q});
  // t > -0.025  <=>  40*D + L > 0 ;  t < 1.5  <=>  2*D < 3*L
  assign above_c = (dot_e * $signed(EW'(psd_pkg::TOL_MUL)) + len_e) > $signed(EW'(0));
  assign below_c = (dot_e * $signed(EW'(2))) < (len_e * $signed(EW'(3)));
  assign md_c    = dot3_q[DTW-1] ? LW'(-dot3_q) : dot3_q[LW-1:0];

  always_comb begin
    priority if (len2_3_q < ONE_Q) begin
      path_c = psd_pkg::PATH_SHORT;
    end else if (flat3_q) begin
      path_c = psd_pkg::PATH_FLAT;
    end else if (above_c && below_c) begin
      path_c = psd_pkg::PATH_INSIDE;
    end else begin
      path_c = psd_pkg::PATH_OUTSIDE;
    end
  end

  logic              v4_q;
  psd_pkg::path_e    path4_q;
  logic [LW-1:0]     len2_4_q;
  logic [LW-1:0]     a2_4_q;
  logic [2*HW-1:0]   pp_hh_q;
  logic [2*HW-1:0]   pp_hl_q;
  logic [2*HW-1:0]   pp_lh_q;
  logic [2*HW-1:0]   pp_ll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    path4_q  <= path_c;
    len2_4_q <= len2_3_q;
    a2_4_q   <= a2_3_q;
    pp_hh_q  <= (2*HW)'(md_c[LW-1:HW]) * (2*HW)'(md_c[LW-1:HW]);
    pp_hl_q  <= (2*HW)'(md_c[LW-1:HW]) * (2*HW)'(md_c[HW-1:0]);
    pp_lh_q  <= (2*HW)'(md_c[HW-1:0])  * (2*HW)'(md_c[LW-1:HW]);
    pp_ll_q  <= (2*HW)'(md_c[HW-1:0])  * (2*HW)'(md_c[HW-1:0]);
  end

  // ---------------- stage 5: numerator dot^2 ----------------
  logic                v5_q;
  logic [2*LW-1:0]     num5_q;
  logic [LW-1:0]       den5_q;
  logic [TAG_W-1:0]    tag5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num5_q <= ((2*LW)'(pp_hh_q) << (2*HW))
            + (((2*LW)'(pp_hl_q) + (2*LW)'(pp_lh_q)) << HW)
            + (2*LW)'(pp_ll_q);
    den5_q <= len2_4_q;
    tag5_q <= {path4_q, a2_4_q};
  end

  // ---------------- divider: floor(dot^2 / L) ----------------
  // quotient never exceeds A2 on the inside path, so LW bits suffice;
  // on the other paths the quotient is not used
  logic             vdiv;
  logic [LW-1:0]    quo;
  logic [TAG_W-1:0] tag_div;

  psd_div #(
    .W     (LW),
    .TAG_W (TAG_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .num_i   (num5_q),
    .den_i   (den5_q),
    .tag_i   (tag5_q),
    .valid_o (vdiv),
    .quo_o   (quo),
    .tag_o   (tag_div)
  );

  // ---------------- output stage: subtract, rescale, saturate ----------------
  psd_pkg::path_e          path_f;
  logic [LW-1:0]           a2_f;
  logic [LW-1:0]           val_f;
  logic [XW-1:0]           scaled_f;
  logic [psd_pkg::OUT_W-1:0] dist_d;

  assign path_f = psd_pkg::path_e'(tag_div[LW+1:LW]);
  assign a2_f   = tag_div[LW-1:0];

  always_comb begin
    // distance to the projected point never goes below zero
    val_f = (quo >= a2_f) ? '0 : a2_f - quo;
    if (path_f != psd_pkg::PATH_INSIDE) begin
      val_f = a2_f;
    end
    scaled_f = (XW'(val_f) << SHL) >> SHR;
    unique case (path_f)
      psd_pkg::PATH_OUTSIDE: dist_d = psd_pkg::SENTINEL_Q16;
      default: begin
        if (scaled_f > XW'(psd_pkg::OUT_MAX)) begin
          dist_d = psd_pkg::OUT_MAX;
        end else begin
          dist_d = scaled_f[psd_pkg::OUT_W-1:0];
        end
      end
    endcase
  end

  logic                      valid_q;
  logic [psd_pkg::OUT_W-1:0] dist_q;
  logic [1:0]                path_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vdiv;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    path_q <= path_f;
  end

  assign valid_o      = valid_q;
  assign dist_sq_o    = dist_q;
  assign path_taken_o = path_q;

  // ---------------- assertions ----------------
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT valid_o)
    else $error("accepted word did not produce a result on time");

  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LAT))
    else $error("result without a matching accepted word");

  a_short_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && (len2_3_q < ONE_Q)) |=> (path4_q == psd_pkg::PATH_SHORT))
    else $error("short segment not classified as short");

  a_outside_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (path_taken_o == psd_pkg::PATH_OUTSIDE))
      |-> (dist_sq_o == psd_pkg::SENTINEL_Q16))
    else $error("outside path did not return the sentinel");

endmodule

// File: sim/point_segment_distance_sq_tb.sv
// ----------------------------------------------------------------------------
// point_segment_distance_sq_tb - self-checking bench for the distance block
// drives point/segment words through the command port, predicts each squared
// distance and path code in plain integer math and checks every strobed result
// ----------------------------------------------------------------------------
module point_segment_distance_sq_tb;

  import psd_pkg::*;

  localparam int unsigned CW       = COORD_WIDTH_DEF;
  localparam int unsigned LATENCY  = 2 * CW + 8;
  localparam int unsigned N_RANDOM = 1100;

  // coordinates in port order: point xyz, start xyz, end xyz
  typedef logic signed [CW-1:0] coords_t [9];

  typedef struct {
    logic [OUT_W-1:0] dist_val;
    path_e            path;
  } dist_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: squared distance predictor plus queue of pending results
  // --------------------------------------------------------------------------
  class dist_scoreboard;
    dist_result_t pending[$];
    int           mismatches;
    int           matched;
    int           path_count[4];

    // clamp a q32.16 value to the output field
    function logic [OUT_W-1:0] clamp_q16(longint unsigned v);
      return (v > longint'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
    endfunction

    function dist_result_t predict(coords_t c);
      dist_result_t r;
      longint       a[3];
      longint       d[3];
      longint       len2;
      longint       a2;
      longint       dot;
      longint       dz_mag;
      logic [127:0] dot_mag;
      logic [127:0] quo;
      len2 = 0;
      a2   = 0;
      dot  = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = longint'(c[i]) - longint'(c[3+i]);
        d[i] = longint'(c[6+i]) - longint'(c[3+i]);
        len2 += d[i] * d[i];
        a2   += a[i] * a[i];
        dot  += a[i] * d[i];
      end
      dz_mag = (d[2] < 0) ? -d[2] : d[2];
      // 2*FRAC_BITS = 16 fraction bits, already the output format
      if (len2 < (longint'(1) << (2 * FRAC_BITS_DEF))) begin
        r.path     = PATH_SHORT;
        r.dist_val = clamp_q16(a2);
      end else if (TOL_MUL * dz_mag < (longint'(1) << FRAC_BITS_DEF)) begin
        r.path     = PATH_FLAT;
        r.dist_val = clamp_q16(a2);
      end else if (dot * longint'(TOL_MUL) + len2 > 0 && dot * 2 < len2 * 3) begin
        // a2 - floor(dot^2 / len2), never below zero
        dot_mag    = (dot < 0) ? 128'(-dot) : 128'(dot);
        quo        = (dot_mag * dot_mag) / 128'(len2);
        r.path     = PATH_INSIDE;
        r.dist_val = (quo >= 128'(a2)) ? '0 : clamp_q16(a2 - longint'(quo[63:0]));
      end else begin
        r.path     = PATH_OUTSIDE;
        r.dist_val = SENTINEL_Q16;
      end
      return r;
    endfunction

    function void note_word(coords_t c);
      pending.push_back(predict(c));
    endfunction

    function void check_result(logic [OUT_W-1:0] dist_val, logic [1:0] path);
      dist_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result dist=%0h path=%0d", dist_val, path);
        return;
      end
      want = pending.pop_front();
      if (dist_val !== want.dist_val || path !== want.path) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected dist=%0h path=%0d, got dist=%0h path=%0d",
                   want.dist_val, want.path, dist_val, path);
      end else begin
        matched++;
        path_count[want.path]++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // dut hookup
  // --------------------------------------------------------------------------
  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [CW-1:0]    coord [9];
  logic                    valid;
  logic [OUT_W-1:0]        dist_sq;
  logic [1:0]              path_taken;

  dist_scoreboard sb;

  point_segment_distance_sq dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .point_x_i   (coord[0]),
    .point_y_i   (coord[1]),
    .point_z_i   (coord[2]),
    .start_x_i   (coord[3]),
    .start_y_i   (coord[4]),
    .start_z_i   (coord[5]),
    .end_x_i     (coord[6]),
    .end_y_i     (coord[7]),
    .end_z_i     (coord[8]),
    .valid_o     (valid),
    .dist_sq_o   (dist_sq),
    .path_taken_o(path_taken)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fixed ceiling on the whole run, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // monitor: a word is taken on the edge with start high and busy low,
  // a result is taken on the edge that ends its strobe cycle
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      coords_t c;
      for (int i = 0; i < 9; i++) c[i] = coord[i];
      sb.note_word(c);
    end
    if (rst_n && valid)
      sb.check_result(dist_sq, path_taken);
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // present one word from the falling edge and hold it until it is taken
  task automatic send_word(coords_t c);
    @(negedge clk);
    for (int i = 0; i < 9; i++) coord[i] <= c[i];
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // drop start and hold it low; n gives the length of the gap
  task automatic idle_cycles(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // random idle after a word, sometimes long, with the given percentage
  task automatic maybe_idle(int pct);
    if ($urandom_range(99) < pct)
      idle_cycles($urandom_range(1, ($urandom_range(9) == 0) ? 12 : 3));
  endtask

  // wait for every pending result, with the pipe fully drained
  task automatic drain_results();
    idle_cycles(1);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    return CW'($urandom);
  endfunction

  // random word shaped so that most fall into a near scene and reach
  // the projection and divide, the rest are wild or degenerate
  function automatic coords_t rand_word();
    coords_t c;
    int      mode;
    int      sc;
    int      base;
    mode = $urandom_range(9);
    sc   = $urandom_range(4, 21);
    for (int i = 0; i < 9; i++) c[i] = rand_coord();
    if (mode >= 3) begin
      // near scene: small offsets around a common base per axis
      for (int ax = 0; ax < 3; ax++) begin
        base = $signed(CW'($urandom)) >>> 2;
        c[ax]   = CW'(base + $signed($urandom_range(0, 2 << sc)) - (1 << sc));
        c[3+ax] = CW'(base + $signed($urandom_range(0, 2 << sc)) - (1 << sc));
        c[6+ax] = CW'(c[3+ax] + $signed($urandom_range(0, 2 << sc)) - (1 << sc));
      end
      if (mode == 8)        // short segment, length under one
        for (int ax = 0; ax < 3; ax++)
          c[6+ax] = CW'(c[3+ax] + $signed($urandom_range(0, 250)) - 125);
      else if (mode == 9)   // z span within or just past the flat tolerance
        c[8] = CW'(c[5] + $signed($urandom_range(0, 14)) - 7);
    end
    return c;
  endfunction

  function automatic coords_t make_word(int px, int py, int pz, int sx, int sy,
                                        int sz, int ex, int ey, int ez);
    coords_t c;
    c = '{CW'(px), CW'(py), CW'(pz), CW'(sx), CW'(sy), CW'(sz),
          CW'(ex), CW'(ey), CW'(ez)};
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int CMIN = -(1 << (CW - 1));

  initial begin
    coords_t dir[$];
    int      idle_pct;

    sb    = new();
    rst_n = 1'b0;
    start = 1'b0;
    for (int i = 0; i < 9; i++) coord[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words: extremes, every path, both t bounds
    dir.push_back(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(make_word(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    dir.push_back(make_word(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    dir.push_back(make_word(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX));
    dir.push_back(make_word(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN));
    dir.push_back(make_word(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    dir.push_back(make_word(0, 0, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    // short segment: length just under and exactly one
    dir.push_back(make_word(512, 300, -700, 0, 0, 0, 255, 0, 0));
    dir.push_back(make_word(512, 300, -700, 0, 0, 0, 256, 0, 0));
    // flat z: dz = 6 is flat, dz = 7 is not
    dir.push_back(make_word(100, 2000, 50, 0, 0, 0, 4096, 0, 6));
    dir.push_back(make_word(100, 2000, 50, 0, 0, 0, 4096, 0, 7));
    dir.push_back(make_word(100, 2000, 50, 0, 0, 0, 4096, 0, -6));
    // t exactly at -0.025 and 1.5 (both outside), and just within each
    dir.push_back(make_word(300, 0, -32, 0, 0, 0, 0, 0, 1280));
    dir.push_back(make_word(300, 0, -31, 0, 0, 0, 0, 0, 1280));
    dir.push_back(make_word(300, 0, 1920, 0, 0, 0, 0, 0, 1280));
    dir.push_back(make_word(300, 0, 1919, 0, 0, 0, 0, 0, 1280));
    // inside with zero distance, and two words far outside
    dir.push_back(make_word(640, 640, 640, 0, 0, 0, 1280, 1280, 1280));
    dir.push_back(make_word(9000, -5000, 700, 100, 100, 100, 900, -400, 2100));
    dir.push_back(make_word(-90000, 0, 0, 0, 0, 0, 1000, 0, 1000));
    foreach (dir[k]) begin
      send_word(dir[k]);
      maybe_idle(30);
    end
    drain_results();

    // three phases: light sender gaps, heavy sender gaps, back to back
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 18 : (ph == 1) ? 71 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        send_word(rand_word());
        // some stretches with no gaps even in the idling phases
        if ((n / 40) % 3 != 2) maybe_idle(idle_pct);
      end
      // hold off until every result of the phase is back
      drain_results();
    end

    $display("checked %0d results: %0d short, %0d flat, %0d inside, %0d outside",
             sb.matched, sb.path_count[0], sb.path_count[1], sb.path_count[2],
             sb.path_count[3]);
    $display("directed extremes and t bounds, then three gap profiles of random words");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/psd_pkg.sv
hw/rtl/psd_div.sv
hw/rtl/point_segment_distance_sq.sv
sim/point_segment_distance_sq_tb.sv
